// ===== src/rsame_pkg.sv =====
// Shared types and constants for the RSA modular exponentiation engine.
// No dependencies; imported by rsame_mmul and rsa_modular_exponentiation.
package rsame_pkg;

    localparam int DATA_W    = 32;          // width of value, result and exponents
    localparam int MOD_W     = 32;          // modulus bits in use
    localparam int EXT_W     = MOD_W + 3;   // signed room for 2P + b - 2n
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRV_EXP = 2'd2;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_STEP,
        S_MACC,
        S_MSQ,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_SETUP,
        MM_RUN
    } t_mm_state;

endpackage

// ===== src/rsame_mmul.sv =====
// Bit-serial interleaved modular multiplier: p = a * b mod n, a scanned MSB first.
// Depends on rsame_pkg. Needs b < n + 2; result is below n.
module rsame_mmul import rsame_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DATA_W-1:0] i_a,
    input  logic [MOD_W-1:0]  i_b,
    input  logic [MOD_W-1:0]  i_n,
    output logic             o_done,
    output logic [MOD_W-1:0]  o_p
);

    t_mm_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic r_done, n_done;

    logic [DATA_W-1:0] r_a;
    logic [MOD_W-1:0]  r_b, r_n, r_p;
    logic signed [EXT_W-1:0] r_b1, r_b2, r_z1, r_z2;

    logic signed [EXT_W-1:0] b_ext, n_ext, p2, add0, add1, add2, c0, c1, c2;
    logic [MOD_W-1:0] p_next;

    assign b_ext = EXT_W'(r_b);
    assign n_ext = EXT_W'(r_n);

    // One step: 2P + a_i*b, then take off 0, n or 2n, whichever leaves it in [0, n)
    assign p2   = EXT_W'(r_p) <<< 1;
    assign add0 = r_a[DATA_W-1] ? b_ext : '0;
    assign add1 = r_a[DATA_W-1] ? r_b1 : r_z1;
    assign add2 = r_a[DATA_W-1] ? r_b2 : r_z2;
    assign c0   = p2 + add0;
    assign c1   = p2 + add1;
    assign c2   = p2 + add2;

    always_comb begin
        if (!c2[EXT_W-1]) begin
            p_next = c2[MOD_W-1:0];
        end else if (!c1[EXT_W-1]) begin
            p_next = c1[MOD_W-1:0];
        end else begin
            p_next = c0[MOD_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            MM_IDLE: begin
                if (i_start) begin
                    n_state = MM_SETUP;
                end
            end
            MM_SETUP: begin
                n_state = MM_RUN;
            end
            MM_RUN: begin
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = MM_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MM_IDLE: begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_n   <= i_n;
                r_p   <= '0;
                r_cnt <= '0;
            end
            MM_SETUP: begin
                r_b1 <= b_ext - n_ext;
                r_b2 <= b_ext - (n_ext <<< 1);
                r_z1 <= -n_ext;
                r_z2 <= -(n_ext <<< 1);
            end
            MM_RUN: begin
                r_p   <= p_next;
                r_a   <= {r_a[DATA_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== src/rsa_modular_exponentiation.sv =====
// Top level of the RSA engine: configuration, square-and-multiply sequencer, output register.
// Depends on rsame_pkg and rsame_mmul.
//
//  channel | signals                               | request
//  --------+---------------------------------------+------------------------------
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data     | register write, no wait
//  in      | i_in_valid/o_in_ready, i_func, i_value| one encrypt or decrypt
//  out     | o_out_valid/i_out_ready, o_result,    | one result per request
//          | o_status                              |
//
// One request at a time. Each modular multiply in the shared bit-serial unit runs its start,
// a setup step, one step per value bit and the hand-back of the product; a request costs
// one reduction plus one square per exponent bit below its top set bit and one multiply per
// set bit. Rejected requests and a zero modulus skip the multiplier and go straight to
// S_DONE. Reset is synchronous, active low, and loads the register defaults. A new request
// is taken while a result still waits.
module rsa_modular_exponentiation import rsame_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [DATA_W-1:0]    i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_result,
    output logic                 o_status
);

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_modulus, r_pub, r_priv;
    logic [DATA_W-1:0] r_exp, n_exp;
    logic [MOD_W-1:0]  r_n, n_n, r_acc, n_acc, r_sq, n_sq;
    logic              r_stat, n_stat;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_result, n_result;
    logic              r_status, n_status;

    logic              mm_start, mm_done;
    logic [DATA_W-1:0] mm_a;
    logic [MOD_W-1:0]  mm_b, mm_p;
    logic [MOD_W-1:0]  cfg_n;

    assign cfg_n = r_modulus[MOD_W-1:0];

    // the unit latches its modulus on the start cycle, so it takes the incoming one
    rsame_mmul u_mmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_n     (n_n),
        .o_done  (mm_done),
        .o_p     (mm_p)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= DATA_W'(2);
            r_pub     <= DATA_W'(65537);
            r_priv    <= DATA_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS: r_modulus <= i_cfg_data;
                CFG_PUB_EXP: r_pub     <= i_cfg_data;
                CFG_PRV_EXP: r_priv    <= i_cfg_data;
                default:     r_modulus <= r_modulus;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_n         = r_n;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        n_status    = r_status;
        mm_start    = 1'b0;
        mm_a        = '0;
        mm_b        = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n    = cfg_n;
                    n_exp  = (i_func == FUNC_DEC) ? r_priv : r_pub;
                    n_acc  = (cfg_n == MOD_W'(1)) ? '0 : MOD_W'(1);
                    n_stat = ST_OK;
                    if (i_func == FUNC_ENC && i_value >= DATA_W'(cfg_n)) begin
                        n_acc   = '0;
                        n_stat  = ST_RANGE;
                        n_state = S_DONE;
                    end else if (cfg_n == '0) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        // reduce the base first: value * 1 mod n
                        mm_start = 1'b1;
                        mm_a     = i_value;
                        mm_b     = MOD_W'(1);
                        n_state  = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_sq    = mm_p;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    mm_start = 1'b1;
                    mm_a     = DATA_W'(r_acc);
                    mm_b     = r_sq;
                    n_state  = S_MACC;
                end else begin
                    mm_start = 1'b1;
                    mm_a     = DATA_W'(r_sq);
                    mm_b     = r_sq;
                    n_state  = S_MSQ;
                end
            end
            S_MACC: begin
                if (mm_done) begin
                    n_acc   = mm_p;
                    n_exp   = {r_exp[DATA_W-1:1], 1'b0};
                    n_state = S_STEP;
                end
            end
            S_MSQ: begin
                if (mm_done) begin
                    n_sq    = mm_p;
                    n_exp   = r_exp >> 1;
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_result    = DATA_W'(r_acc);
                    n_status    = r_stat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp    <= n_exp;
        r_n      <= n_n;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_stat   <= n_stat;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;

`ifndef ASSERT_OFF
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == S_RED || r_state == S_MACC || r_state == S_MSQ))
        else $error("multiplier finished with no multiply outstanding");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_RANGE) |-> (o_result == '0))
        else $error("rejected request carries a non-zero result");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && cfg_n != '0) |-> (o_result < DATA_W'(cfg_n)))
        else $error("result not reduced below the modulus");

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |=> !mm_start)
        else $error("multiplier started on back-to-back cycles");
`endif

endmodule
